>>> src/gcm_pkg.sv
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared constants, codes and control types of the Gaussian cluster
// merge/remove block.
// ----------------------------------------------------------------------------
package gcm_pkg;

  localparam int DEF_COUNT_BITS = 24;
  localparam int DEF_VALUE_BITS = 32;
  localparam int DEF_FRAC_BITS  = 16;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  localparam logic [2:0] OP_HOLD   = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_MERGE  = 3'd3;
  localparam logic [2:0] OP_REMOVE = 3'd4;

  localparam logic CMD_MERGE  = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam int NUM_VALUES = 9;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] status;
  } gcm_ctl_t;

  localparam int CTL_BITS = $bits(gcm_ctl_t);

  // covariance entry -> row / column of the mean vector
  function automatic logic [1:0] row_of(input logic [2:0] e);
    logic [1:0] r;
    case (e)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] col_of(input logic [2:0] e);
    logic [1:0] c;
    case (e)
      3'd0:       c = 2'd0;
      3'd1, 3'd3: c = 2'd1;
      default:    c = 2'd2;
    endcase
    return c;
  endfunction

endpackage

>>> src/gcm_front.sv
// ----------------------------------------------------------------------------
// gcm_front
// Accepts input transactions, classifies them against a shadow point count
// and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module gcm_front import gcm_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int QW         = CTL_BITS + 3 * COUNT_BITS + 1 + NUM_VALUES * VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         cmd,
  input  logic [COUNT_BITS-1:0]        count_in,
  input  logic [NUM_VALUES*VALUE_BITS-1:0] values,
  output logic                         push_valid,
  input  logic                         push_ready,
  output logic [QW-1:0]                push_data
);

  logic [COUNT_BITS-1:0] shadow_count;
  logic [COUNT_BITS-1:0] shadow_count_next;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS:0]   dv;
  gcm_ctl_t              ctl;

  always_comb begin
    sum = {1'b0, shadow_count} + {1'b0, count_in};
    ctl.op = OP_HOLD;
    ctl.status = ST_OK;
    dv = '0;
    shadow_count_next = shadow_count;
    if (cmd == CMD_MERGE) begin
      if (shadow_count == '0 && count_in == '0) begin
        ctl.status = ST_EMPTY;
      end else if (shadow_count == '0) begin
        ctl.op = OP_LOAD;
        shadow_count_next = count_in;
      end else if (count_in != '0) begin
        ctl.op = OP_MERGE;
        dv = sum;
        shadow_count_next = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
      end
    end else begin
      if (count_in > shadow_count) begin
        ctl.status = ST_OVER;
      end else if (count_in == shadow_count) begin
        ctl.op = OP_CLEAR;
        shadow_count_next = '0;
      end else begin
        ctl.op = OP_REMOVE;
        dv = {1'b0, shadow_count - count_in};
        shadow_count_next = shadow_count - count_in;
      end
    end
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign push_data  = {ctl, count_in, dv, shadow_count_next, values};

  always_ff @(posedge clk) begin
    if (rst) begin
      shadow_count <= '0;
    end else if (in_valid && push_ready) begin
      shadow_count <= shadow_count_next;
    end
  end

endmodule

>>> src/gcm_queue.sv
// ----------------------------------------------------------------------------
// gcm_queue
// Two-entry queue between the classifier and the execution engine.
// ----------------------------------------------------------------------------
module gcm_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   fill;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = mem[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop)  rp <= ~rp;
      if (do_push && !do_pop)      fill <= fill + 2'd1;
      else if (!do_push && do_pop) fill <= fill - 2'd1;
    end
  end

endmodule

>>> src/gcm_div.sv
// ----------------------------------------------------------------------------
// gcm_div
// Restoring divider, one quotient bit per cycle. Signed dividend, unsigned
// divisor, quotient truncated toward zero and saturated to VALUE_BITS.
// ----------------------------------------------------------------------------
module gcm_div #(
  parameter int AW         = 104,
  parameter int NW         = 25,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [AW-1:0]         dividend,
  input  logic [NW-1:0]                divisor,
  output logic                         done,
  output logic signed [VALUE_BITS-1:0] quotient
);

  localparam int CW = $clog2(AW + 1);
  localparam logic [AW-1:0] LIM = AW'(1) << (VALUE_BITS - 1);

  logic [AW-1:0] dq;
  logic [NW-1:0] rem;
  logic [NW-1:0] dsr;
  logic          neg;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [NW:0]   rs;
  logic          ge;

  assign rs = {rem, dq[AW-1]};
  assign ge = (rs >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[AW-1];
      dq  <= dividend[AW-1] ? AW'(-dividend) : AW'(dividend);
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? NW'(rs - {1'b0, dsr}) : rs[NW-1:0];
      dq  <= {dq[AW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(AW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (neg) begin
      quotient = (dq > LIM) ? {1'b1, {(VALUE_BITS-1){1'b0}}} : VALUE_BITS'(-dq);
    end else begin
      quotient = (dq > LIM - AW'(1)) ? {1'b0, {(VALUE_BITS-1){1'b1}}} : VALUE_BITS'(dq);
    end
  end

endmodule

>>> src/gcm_back.sv
// ----------------------------------------------------------------------------
// gcm_back
// Execution engine: holds the cluster state, runs the pooled merge/remove
// arithmetic on a shared multiplier and divider, and registers the result.
// ----------------------------------------------------------------------------
module gcm_back import gcm_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int QW         = CTL_BITS + 3 * COUNT_BITS + 1 + NUM_VALUES * VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [QW-1:0]                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [COUNT_BITS-1:0]        count_out,
  output logic signed [VALUE_BITS-1:0] mean_out [3],
  output logic signed [VALUE_BITS-1:0] cov_out [6]
);

  localparam int V  = VALUE_BITS;
  localparam int MW = ((VALUE_BITS > COUNT_BITS + 1) ? VALUE_BITS : COUNT_BITS + 1) + 1;
  localparam int OW = MW + 1;
  localparam int PW = 2 * OW - FRAC_BITS;
  localparam int AW = 2 * OW + MW + 3;
  localparam int NW = COUNT_BITS + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OPA  = 3'd1;
  localparam logic [2:0] S_OPB  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_WAIT = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  // term order within one element
  localparam logic [2:0] T_OLD  = 3'd0;
  localparam logic [2:0] T_IN   = 3'd1;
  localparam logic [2:0] T_P1   = 3'd2;
  localparam logic [2:0] T_P1LO = 3'd3;
  localparam logic [2:0] T_P1HI = 3'd4;
  localparam logic [2:0] T_P2   = 3'd5;
  localparam logic [2:0] T_P2LO = 3'd6;
  localparam logic [2:0] T_P2HI = 3'd7;

  logic [2:0]                state;
  logic                      cov_ph;
  logic [2:0]                idx;
  logic [2:0]                t;

  logic [COUNT_BITS-1:0]     count;
  logic signed [V-1:0]       mean [3];
  logic signed [V-1:0]       cov [6];
  logic signed [V:0]         d1 [3];
  logic signed [V:0]         d2 [3];

  gcm_ctl_t                  it_ctl;
  logic [COUNT_BITS-1:0]     it_n2;
  logic [NW-1:0]             it_div;
  logic [COUNT_BITS-1:0]     it_nc;
  logic signed [V-1:0]       it_m2 [3];
  logic signed [V-1:0]       it_c2 [6];

  gcm_ctl_t                  q_ctl;
  logic [COUNT_BITS-1:0]     q_n2;
  logic [NW-1:0]             q_div;
  logic [COUNT_BITS-1:0]     q_nc;
  logic signed [V-1:0]       q_val [NUM_VALUES];

  logic signed [OW-1:0]      opa;
  logic signed [OW-1:0]      opb;
  logic signed [OW-1:0]      src_a;
  logic signed [OW-1:0]      src_b;
  logic signed [2*OW-1:0]    prod;
  logic signed [2*OW-1:0]    pt;
  logic signed [PW-1:0]      p;
  logic signed [PW-1:0]      p_hi;
  logic signed [AW-1:0]      acc;
  logic signed [AW-1:0]      term;

  logic                      is_merge;
  logic [COUNT_BITS-1:0]     w1;
  logic [1:0]                d_addr;
  logic [1:0]                k;
  logic signed [V-1:0]       cur_old;
  logic signed [V-1:0]       cur_in;
  logic                      last_t;
  logic                      acc_sub;
  logic                      out_free;

  logic                      div_start;
  logic                      div_done;
  logic signed [V-1:0]       div_q;

  always_comb begin
    {q_ctl, q_n2, q_div, q_nc} = in_data[QW-1 -: CTL_BITS + 3 * COUNT_BITS + 1];
    for (int j = 0; j < NUM_VALUES; j++) begin
      q_val[j] = in_data[(NUM_VALUES - 1 - j) * V +: V];
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign is_merge  = (it_ctl.op == OP_MERGE);
  assign w1        = is_merge ? count : it_div[COUNT_BITS-1:0];
  assign d_addr    = (state == S_OPA) ? row_of(idx) : col_of(idx);
  assign k         = idx[1:0];
  assign cur_old   = cov_ph ? cov[idx] : mean[k];
  assign cur_in    = cov_ph ? it_c2[idx] : it_m2[k];
  assign last_t    = cov_ph ? (t == T_P2HI) : (t == T_IN);
  assign acc_sub   = (t != T_OLD) && !is_merge;
  assign p_hi      = p >>> MW;
  assign div_start = (state == S_DIV);

  always_comb begin
    case (t)
      T_OLD:                 src_a = OW'(count);
      T_IN, T_P2LO, T_P2HI:  src_a = OW'(it_n2);
      T_P1LO, T_P1HI:        src_a = OW'(w1);
      T_P1:                  src_a = OW'(d1[d_addr]);
      T_P2:                  src_a = OW'(d2[d_addr]);
      default:               src_a = '0;
    endcase
    case (t)
      T_OLD:                 src_b = OW'(cur_old);
      T_IN:                  src_b = OW'(cur_in);
      T_P1:                  src_b = OW'(d1[d_addr]);
      T_P2:                  src_b = OW'(d2[d_addr]);
      T_P1LO, T_P2LO:        src_b = OW'(p[MW-1:0]);
      T_P1HI, T_P2HI:        src_b = OW'(p_hi);
      default:               src_b = '0;
    endcase
  end

  always_comb begin
    pt = prod >>> FRAC_BITS;
    if (prod[2*OW-1] && (|prod[FRAC_BITS-1:0])) pt = pt + (2*OW)'(1);
    term = AW'(prod);
    if (t == T_P1HI || t == T_P2HI) term = term <<< MW;
  end

  gcm_div #(
    .AW(AW),
    .NW(NW),
    .VALUE_BITS(V)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(acc),
    .divisor(it_div),
    .done(div_done),
    .quotient(div_q)
  );

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          it_ctl <= q_ctl;
          it_n2  <= q_n2;
          it_div <= q_div;
          it_nc  <= q_nc;
          for (int j = 0; j < 3; j++) it_m2[j] <= q_val[j];
          for (int j = 0; j < 6; j++) it_c2[j] <= q_val[3 + j];
          acc <= '0;
        end
      end
      S_OPA: opa  <= src_a;
      S_OPB: opb  <= src_b;
      S_MUL: prod <= opa * opb;
      S_ACC: begin
        if (t == T_P1 || t == T_P2) begin
          p <= PW'(pt);
        end else begin
          acc <= acc_sub ? acc - term : acc + term;
        end
      end
      S_WAIT: begin
        if (div_done) begin
          acc <= '0;
          if (!cov_ph) begin
            d1[k] <= (V+1)'(mean[k]) - (V+1)'(div_q);
            d2[k] <= (V+1)'(it_m2[k]) - (V+1)'(is_merge ? div_q : mean[k]);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // state registers and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cov_ph    <= 1'b0;
      idx       <= '0;
      t         <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      for (int j = 0; j < 3; j++) mean[j] <= '0;
      for (int j = 0; j < 6; j++) cov[j] <= '0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cov_ph <= 1'b0;
            idx    <= '0;
            t      <= T_OLD;
            case (q_ctl.op)
              OP_MERGE, OP_REMOVE: state <= S_OPA;
              OP_LOAD: begin
                for (int j = 0; j < 3; j++) mean[j] <= q_val[j];
                for (int j = 0; j < 6; j++) cov[j] <= q_val[3 + j];
                state <= S_DONE;
              end
              OP_CLEAR: begin
                for (int j = 0; j < 3; j++) mean[j] <= '0;
                for (int j = 0; j < 6; j++) cov[j] <= '0;
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_OPA: state <= S_OPB;
        S_OPB: state <= S_MUL;
        S_MUL: state <= S_ACC;
        S_ACC: begin
          if (last_t) begin
            state <= S_DIV;
          end else begin
            t     <= t + 3'd1;
            state <= S_OPA;
          end
        end
        S_DIV: state <= S_WAIT;
        S_WAIT: begin
          if (div_done) begin
            t <= T_OLD;
            if (!cov_ph) begin
              mean[k] <= div_q;
              if (idx == 3'd2) begin
                cov_ph <= 1'b1;
                idx    <= '0;
              end else begin
                idx <= idx + 3'd1;
              end
              state <= S_OPA;
            end else begin
              cov[idx] <= div_q;
              if (idx == 3'd5) begin
                state <= S_DONE;
              end else begin
                idx   <= idx + 3'd1;
                state <= S_OPA;
              end
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            count <= it_nc;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status    <= it_ctl.status;
      count_out <= it_nc;
      for (int j = 0; j < 3; j++) mean_out[j] <= mean[j];
      for (int j = 0; j < 6; j++) cov_out[j] <= cov[j];
    end
  end

endmodule

>>> src/gaussian_cluster_merge_remove.sv
// ----------------------------------------------------------------------------
// gaussian_cluster_merge_remove
// Running 3D Gaussian cluster (count, mean, upper-triangle covariance) with
// merge and remove of a second cluster, signed fixed point, saturating.
//
// A classifier checks each transaction against its own copy of the point
// count and queues it (two entries); the engine then works it. Error, hold,
// load and clear transactions skip the arithmetic. A full merge or remove
// runs every term through one shared multiplier (states S_OPA, S_OPB, S_MUL
// and S_ACC per product) and one restoring divider (1 quotient bit per cycle,
// AW = 2*OW+MW+3 bits, MW = max(VALUE_BITS, COUNT_BITS+1)+1, OW = MW+1).
// Results go out through a register, so the next transaction can be
// accepted while the previous result waits.
// ----------------------------------------------------------------------------
module gaussian_cluster_merge_remove import gcm_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         cmd,
  input  logic [COUNT_BITS-1:0]        count_in,
  input  logic signed [VALUE_BITS-1:0] mean_x_in,
  input  logic signed [VALUE_BITS-1:0] mean_y_in,
  input  logic signed [VALUE_BITS-1:0] mean_z_in,
  input  logic signed [VALUE_BITS-1:0] cov_xx_in,
  input  logic signed [VALUE_BITS-1:0] cov_xy_in,
  input  logic signed [VALUE_BITS-1:0] cov_xz_in,
  input  logic signed [VALUE_BITS-1:0] cov_yy_in,
  input  logic signed [VALUE_BITS-1:0] cov_yz_in,
  input  logic signed [VALUE_BITS-1:0] cov_zz_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [COUNT_BITS-1:0]        count_out,
  output logic signed [VALUE_BITS-1:0] mean_x_out,
  output logic signed [VALUE_BITS-1:0] mean_y_out,
  output logic signed [VALUE_BITS-1:0] mean_z_out,
  output logic signed [VALUE_BITS-1:0] cov_xx_out,
  output logic signed [VALUE_BITS-1:0] cov_xy_out,
  output logic signed [VALUE_BITS-1:0] cov_xz_out,
  output logic signed [VALUE_BITS-1:0] cov_yy_out,
  output logic signed [VALUE_BITS-1:0] cov_yz_out,
  output logic signed [VALUE_BITS-1:0] cov_zz_out
);

  localparam int QW = CTL_BITS + 3 * COUNT_BITS + 1 + NUM_VALUES * VALUE_BITS;

  logic                                push_valid;
  logic                                push_ready;
  logic [QW-1:0]                       push_data;
  logic                                pop_valid;
  logic                                pop_ready;
  logic [QW-1:0]                       pop_data;
  logic [NUM_VALUES*VALUE_BITS-1:0]    values;
  logic signed [VALUE_BITS-1:0]        mean_o [3];
  logic signed [VALUE_BITS-1:0]        cov_o [6];

  assign values = {mean_x_in, mean_y_in, mean_z_in,
                   cov_xx_in, cov_xy_in, cov_xz_in, cov_yy_in, cov_yz_in, cov_zz_in};

  gcm_front #(
    .COUNT_BITS(COUNT_BITS),
    .VALUE_BITS(VALUE_BITS),
    .QW(QW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .count_in(count_in),
    .values(values),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data(push_data)
  );

  gcm_queue #(
    .W(QW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data(push_data),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data(pop_data)
  );

  gcm_back #(
    .COUNT_BITS(COUNT_BITS),
    .VALUE_BITS(VALUE_BITS),
    .FRAC_BITS(FRAC_BITS),
    .QW(QW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .in_valid(pop_valid),
    .in_ready(pop_ready),
    .in_data(pop_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .count_out(count_out),
    .mean_out(mean_o),
    .cov_out(cov_o)
  );

  assign mean_x_out = mean_o[0];
  assign mean_y_out = mean_o[1];
  assign mean_z_out = mean_o[2];
  assign cov_xx_out = cov_o[0];
  assign cov_xy_out = cov_o[1];
  assign cov_xz_out = cov_o[2];
  assign cov_yy_out = cov_o[3];
  assign cov_yz_out = cov_o[4];
  assign cov_zz_out = cov_o[5];

endmodule

>>> src/gcm_checker.sv
// ----------------------------------------------------------------------------
// gcm_checker
// Port-level checks of the Gaussian cluster merge/remove block.
// ----------------------------------------------------------------------------
module gcm_checker import gcm_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   status,
  input logic [COUNT_BITS-1:0]        count_out,
  input logic signed [VALUE_BITS-1:0] mean_x_out,
  input logic signed [VALUE_BITS-1:0] cov_xx_out,
  input logic signed [VALUE_BITS-1:0] cov_zz_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(count_out) && $stable(status))
    else $error("result transaction changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_OVER))
    else $error("reserved status code");

  a_empty_merge: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> count_out == '0)
    else $error("empty merge reported with stored points");

  a_empty_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && count_out == '0 |->
      mean_x_out == '0 && cov_xx_out == '0 && cov_zz_out == '0)
    else $error("empty cluster holds nonzero values");

endmodule

bind gaussian_cluster_merge_remove gcm_checker #(
  .COUNT_BITS(COUNT_BITS),
  .VALUE_BITS(VALUE_BITS)
) u_gcm_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .status(status),
  .count_out(count_out),
  .mean_x_out(mean_x_out),
  .cov_xx_out(cov_xx_out),
  .cov_zz_out(cov_zz_out)
);
